### rtl/core/frwl_pkg.sv
package frwl_pkg;
	localparam int QUEUE_DEPTH = 16;
	localparam int REQUESTER_COUNT = 256;
	localparam int QW = $clog2(QUEUE_DEPTH);
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);
	localparam int RCW = $clog2(REQUESTER_COUNT + 1);
	localparam int CQ_DEPTH = 2;

	localparam logic [1:0] K_READ = 2'd0;
	localparam logic [1:0] K_WRITE = 2'd1;
	localparam logic [1:0] K_RELEASE = 2'd2;
	localparam logic [1:0] K_CANCEL = 2'd3;

	localparam logic [2:0] ST_GRANTED = 3'd0;
	localparam logic [2:0] ST_QUEUED = 3'd1;
	localparam logic [2:0] ST_WOULD_BLOCK = 3'd2;
	localparam logic [2:0] ST_QUEUE_FULL = 3'd3;
	localparam logic [2:0] ST_RELEASED = 3'd4;
	localparam logic [2:0] ST_RELEASE_UNHELD = 3'd5;
	localparam logic [2:0] ST_CANCELLED = 3'd6;
	localparam logic [2:0] ST_NOT_FOUND = 3'd7;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] requester;
		logic       try_only;
	} cmd_t;
endpackage

### rtl/core/frwl_front.sv
module frwl_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         kind,
	input  logic [7:0]         requester,
	input  logic               try_only,
	output logic               cq_valid,
	output frwl_pkg::cmd_t     cq_cmd,
	input  logic               cq_take
);
	import frwl_pkg::*;

	cmd_t       mem_q [CQ_DEPTH];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'(CQ_DEPTH));
	assign cq_valid = (cnt_q != 2'd0);
	assign cq_cmd = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wp_q] <= '{kind: kind, requester: requester, try_only: try_only};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) wp_q <= ~wp_q;
			if (cq_take && cq_valid) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push && !full) - 2'(cq_take && cq_valid);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'(CQ_DEPTH))
		else $error("command queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n) (push && full && !cq_take) |=> full)
		else $error("full dropped without take");
	assert property (@(posedge clk) disable iff (!arst_n)
		(!cq_valid && !push) |=> !cq_valid)
		else $error("queue filled from nothing");
endmodule

### rtl/core/frwl_back.sv
module frwl_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cq_valid,
	input  frwl_pkg::cmd_t     cq_cmd,
	output logic               cq_take,
	output logic               empty,
	input  logic               pop,
	output logic [7:0]         agent,
	output logic [2:0]         status,
	output logic [8:0]         reader_total,
	output logic               last
);
	import frwl_pkg::*;

	localparam logic [1:0] S_CMD = 2'd0;
	localparam logic [1:0] S_FIND = 2'd1;
	localparam logic [1:0] S_SHIFT = 2'd2;
	localparam logic [1:0] S_WALK = 2'd3;

	logic [1:0]     state_q;
	logic           held_q;
	logic [RCW-1:0] rc_q;
	logic [QCW-1:0] wc_q;
	logic [7:0]     wid_q [QUEUE_DEPTH];
	logic           wwr_q [QUEUE_DEPTH];
	logic [QW-1:0]  idx_q;
	logic           gany_q;
	logic           cwr_q;
	cmd_t           cmd_q;

	logic           ov_q;
	logic [7:0]     agent_q;
	logic [2:0]     status_q;
	logic [8:0]     rt_q;
	logic           last_q;

	logic           can_emit;
	logic           em;
	logic [7:0]     em_agent;
	logic [2:0]     em_status;
	logic [RCW-1:0] em_rc;
	logic           em_last;

	logic           rd_ok;
	logic           qfull;
	logic           rel_walk;
	logic [RCW-1:0] rc_dec;
	logic           head_ok;
	logic           head_wr;
	logic [QCW-1:0] wc_dec;
	logic           walk_more;

	assign empty = !ov_q;
	assign agent = agent_q;
	assign status = status_q;
	assign reader_total = rt_q;
	assign last = last_q;
	assign can_emit = !ov_q || pop;

	assign qfull = (wc_q == QCW'(QUEUE_DEPTH));
	assign rd_ok = (rc_q < RCW'(REQUESTER_COUNT)) && (!held_q || (rc_q != '0 && wc_q == '0));
	assign rc_dec = (rc_q != '0) ? rc_q - 1'b1 : rc_q;
	assign rel_walk = (rc_q == '0) || (rc_dec == '0);
	assign head_wr = wwr_q[0];
	assign head_ok = (wc_q != '0) && (head_wr ? (rc_q == '0) : (rc_q < RCW'(REQUESTER_COUNT)));
	assign wc_dec = wc_q - 1'b1;
	// after granting the head, can the walk grant another
	assign walk_more = !head_wr && (wc_dec != '0) && !wwr_q[1]
		&& (rc_q + 1'b1 < RCW'(REQUESTER_COUNT));

	assign cq_take = (state_q == S_CMD) && cq_valid && can_emit;

	// head grantability once the cancelled entry at idx_q leaves the queue
	function automatic logic head_ok_after();
		logic w;
		begin
			w = (idx_q == '0) ? wwr_q[1] : wwr_q[0];
			head_ok_after = w ? 1'b0 : (rc_q < RCW'(REQUESTER_COUNT));
		end
	endfunction

	always_comb begin
		em = 1'b0;
		em_agent = cmd_q.requester;
		em_status = ST_GRANTED;
		em_rc = rc_q;
		em_last = 1'b1;
		case (state_q)
			S_CMD: begin
				em = cq_take;
				em_agent = cq_cmd.requester;
				case (cq_cmd.kind)
					K_READ: begin
						if (rd_ok) begin
							em_rc = rc_q + 1'b1;
						end else begin
							em_status = cq_cmd.try_only ? ST_WOULD_BLOCK :
								(qfull ? ST_QUEUE_FULL : ST_QUEUED);
						end
					end
					K_WRITE: begin
						if (held_q)
							em_status = cq_cmd.try_only ? ST_WOULD_BLOCK :
								(qfull ? ST_QUEUE_FULL : ST_QUEUED);
					end
					K_RELEASE: begin
						if (!held_q) begin
							em_status = ST_RELEASE_UNHELD;
						end else begin
							em_status = ST_RELEASED;
							em_rc = rc_dec;
							em_last = !(rel_walk && wc_q != '0 && (wwr_q[0] ? rc_dec == '0 :
								rc_dec < RCW'(REQUESTER_COUNT)));
						end
					end
					default: begin
						em = 1'b0;
					end
				endcase
			end
			S_FIND: begin
				em = can_emit && ({1'b0, idx_q} >= wc_q ||
					(wid_q[idx_q] != cmd_q.requester && {1'b0, idx_q} + 1'b1 >= wc_q));
				em_status = ST_NOT_FOUND;
			end
			S_SHIFT: begin
				em = can_emit;
				em_status = ST_CANCELLED;
				em_last = !(cwr_q && rc_q != '0 && wc_q > QCW'(1) && head_ok_after());
			end
			default: begin
				em = can_emit && head_ok;
				em_agent = wid_q[0];
				em_rc = head_wr ? rc_q : rc_q + 1'b1;
				em_last = !walk_more;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (em) begin
			agent_q <= em_agent;
			status_q <= em_status;
			rt_q <= 9'(em_rc);
			last_q <= em_last;
		end
		if (cq_take) begin
			cmd_q <= cq_cmd;
			if ((cq_cmd.kind == K_READ && !rd_ok) || (cq_cmd.kind == K_WRITE && held_q)) begin
				if (!cq_cmd.try_only && !qfull) begin
					wid_q[QW'(wc_q)] <= cq_cmd.requester;
					wwr_q[QW'(wc_q)] <= cq_cmd.kind == K_WRITE;
				end
			end
		end
		if (state_q == S_FIND && {1'b0, idx_q} < wc_q) cwr_q <= wwr_q[idx_q];
		if ((state_q == S_SHIFT || (state_q == S_WALK && em)) && can_emit) begin
			for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
				if (state_q == S_WALK || QW'(i) >= idx_q) begin
					wid_q[i] <= wid_q[i+1];
					wwr_q[i] <= wwr_q[i+1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CMD;
			held_q <= 1'b0;
			rc_q <= '0;
			wc_q <= '0;
			idx_q <= '0;
			gany_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (pop && ov_q) ov_q <= 1'b0;
			if (em) ov_q <= 1'b1;
			case (state_q)
				S_CMD: begin
					if (cq_take) begin
						case (cq_cmd.kind)
							K_READ: begin
								if (rd_ok) begin
									held_q <= 1'b1;
									rc_q <= rc_q + 1'b1;
								end else if (!cq_cmd.try_only && !qfull) begin
									wc_q <= wc_q + 1'b1;
								end
							end
							K_WRITE: begin
								if (!held_q) held_q <= 1'b1;
								else if (!cq_cmd.try_only && !qfull) wc_q <= wc_q + 1'b1;
							end
							K_RELEASE: begin
								if (held_q) begin
									rc_q <= rc_dec;
									if (rel_walk) begin
										gany_q <= 1'b0;
										state_q <= S_WALK;
									end
								end
							end
							default: begin
								idx_q <= '0;
								state_q <= S_FIND;
							end
						endcase
					end
				end
				S_FIND: begin
					if ({1'b0, idx_q} >= wc_q) begin
						if (can_emit) state_q <= S_CMD;
					end else if (wid_q[idx_q] == cmd_q.requester) begin
						state_q <= S_SHIFT;
					end else if ({1'b0, idx_q} + 1'b1 >= wc_q) begin
						if (can_emit) state_q <= S_CMD;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_SHIFT: begin
					if (can_emit) begin
						wc_q <= wc_dec;
						gany_q <= 1'b1;
						state_q <= (cwr_q && rc_q != '0) ? S_WALK : S_CMD;
					end
				end
				default: begin
					if (em) begin
						wc_q <= wc_dec;
						held_q <= 1'b1;
						gany_q <= 1'b1;
						if (!head_wr) rc_q <= rc_q + 1'b1;
						if (!walk_more) state_q <= S_CMD;
					end else if (!head_ok) begin
						if (!gany_q && rc_q == '0) held_q <= 1'b0;
						state_q <= S_CMD;
					end
				end
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) rc_q <= RCW'(REQUESTER_COUNT))
		else $error("reader count overrun");
	assert property (@(posedge clk) disable iff (!arst_n) wc_q <= QCW'(QUEUE_DEPTH))
		else $error("waiter count overrun");
	assert property (@(posedge clk) disable iff (!arst_n) (rc_q != '0) |-> held_q)
		else $error("readers without hold");
	assert property (@(posedge clk) disable iff (!arst_n) (ov_q && !pop) |=> $stable(agent_q))
		else $error("result changed while waiting");
endmodule

### rtl/core/fair_readers_writer_lock_arbiter_top.sv
// Readers-writer lock with a fair waiter queue.
// A push enters the front command queue; the back end takes it and registers its result.
// An acquire or a release without hand-over is done in the command state; cancel scans
// the waiter queue one entry per cycle (up to 16), then closes the gap in the shift state;
// hand-over grants one per cycle; one plain acquire per cycle. Rates hold while results are popped.
// Reset (arst_n low): lock free, no readers, no waiters, no results.
module fair_readers_writer_lock_arbiter_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [1:0] kind,
	input  logic [7:0] requester,
	input  logic       try_only,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] agent,
	output logic [2:0] status,
	output logic [8:0] reader_total,
	output logic       last
);
	import frwl_pkg::*;

	logic cq_valid;
	logic cq_take;
	cmd_t cq_cmd;

	frwl_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .kind(kind),
		.requester(requester), .try_only(try_only), .cq_valid(cq_valid),
		.cq_cmd(cq_cmd), .cq_take(cq_take)
	);

	frwl_back u_back (
		.clk(clk), .arst_n(arst_n), .cq_valid(cq_valid), .cq_cmd(cq_cmd),
		.cq_take(cq_take), .empty(empty), .pop(pop), .agent(agent),
		.status(status), .reader_total(reader_total), .last(last)
	);
endmodule
